[hw/rtl/cmm_pkg.sv]
// Shared types and constants for the complex matrix multiplier.
`timescale 1ns / 1ps
package cmm_pkg;
    localparam int MAX_DIM_DEF = 8;
    localparam int SIZE_CAP    = 8;
    localparam int CFG_W       = 4;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 72;

    localparam logic [1:0] MODE_LOAD_L = 2'd0;
    localparam logic [1:0] MODE_LOAD_R = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_INNER = 2'd1;
    localparam logic [1:0] CFG_COLS  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         row_index;
        logic [2:0]         col_index;
        logic signed [31:0] value_real;
        logic signed [31:0] value_imag;
    } t_req;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] prod_real;
        logic signed [31:0] prod_imag;
        logic               last_of_run;
        logic               status;
    } t_res;

    // size register to effective size: 0 acts as 1, large values clamp
    function automatic logic [4:0] eff_size(input logic [3:0] v, input logic [4:0] cap);
        logic [4:0] r;
        r = {1'b0, v};
        if (v == 4'd0) r = 5'd1;
        if (r > cap) r = cap;
        return r;
    endfunction

    // floor shift by 24 and saturate to 32 bits
    function automatic logic [31:0] acc_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-25:0] s;
        s = a[ACC_W-1:24];
        if (s > $signed(48'sh0000_7FFF_FFFF)) return 32'h7FFF_FFFF;
        if (s < $signed(48'shFFFF_8000_0000)) return 32'h8000_0000;
        return s[31:0];
    endfunction
endpackage

[hw/rtl/complex_matrix_multiply_unit.sv]
// Loads: an in-range load is written to its store in the cycle after acceptance; an
// out-of-range load strobes its error in the cycle right after acceptance.
// A start runs each product element through one complex MAC (4 multipliers), summing
// over the inner dimension; operands, products, accumulator and result are registered
// in turn. Busy stays high until the last element is out; one load per cycle while idle.
// Reset: synchronous, sizes return to 8; stores are undefined until written.
`timescale 1ns / 1ps
module complex_matrix_multiply_unit import cmm_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_strobe,
    output t_res       o_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data
);
    logic [3:0] r_rows, r_inner, r_cols;
    logic [4:0] w_nr, w_nk, w_nc, w_cap;
    logic       w_err_v, w_start, w_wl, w_wr, w_bv, w_bbusy;
    t_res       w_err, w_bres;
    logic [$clog2(MAX_DIM*MAX_DIM)-1:0] w_addr;
    logic [63:0] w_data;

    assign w_cap = (MAX_DIM < SIZE_CAP) ? 5'(MAX_DIM) : 5'(SIZE_CAP);
    assign w_nr = eff_size(r_rows, w_cap);
    assign w_nk = eff_size(r_inner, w_cap);
    assign w_nc = eff_size(r_cols, w_cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 4'd8; r_inner <= 4'd8; r_cols <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS:  r_rows  <= i_cfg_data;
                CFG_INNER: r_inner <= i_cfg_data;
                CFG_COLS:  r_cols  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front stage registers one request; start waits there before the sequencer
    assign busy = w_bbusy || w_start;

    cmm_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk, .i_rst_n, .i_valid(start && !busy), .i_req,
        .i_nr(w_nr), .i_nk(w_nk), .i_nc(w_nc),
        .o_err_valid(w_err_v), .o_err(w_err), .o_start(w_start),
        .o_wr_l(w_wl), .o_wr_r(w_wr), .o_wr_addr(w_addr), .o_wr_data(w_data));

    cmm_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk, .i_rst_n, .i_start(w_start),
        .i_nr(w_nr), .i_nk(w_nk), .i_nc(w_nc),
        .i_wr_l(w_wl), .i_wr_r(w_wr), .i_wr_addr(w_addr), .i_wr_data(w_data),
        .o_busy(w_bbusy), .o_valid(w_bv), .o_res(w_bres));

    // errors only arrive while the sequencer is idle
    assign o_strobe = w_bv || w_err_v;
    assign o_res    = w_bv ? w_bres : w_err;

    a_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_bv && w_err_v)) else $error("error and product collide");
    a_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_bbusy) else $error("start lost");
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.status) |-> !o_res.last_of_run) else $error("bad error result");
endmodule

[hw/rtl/cmm_front.sv]
// Front end: classifies requests, registers store writes, errors and start commands.
`timescale 1ns / 1ps
module cmm_front import cmm_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_req       i_req,
    input  logic [4:0] i_nr,
    input  logic [4:0] i_nk,
    input  logic [4:0] i_nc,
    output logic       o_err_valid,
    output t_res       o_err,
    output logic       o_start,
    output logic       o_wr_l,
    output logic       o_wr_r,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_wr_addr,
    output logic [63:0] o_wr_data
);
    localparam int AW = $clog2(MAX_DIM*MAX_DIM);
    localparam int IW = $clog2(MAX_DIM);
    logic [4:0] w_rlim, w_clim;
    logic       w_load, w_bad;
    logic [IW-1:0] w_r, w_c;

    always_comb begin
        w_load = (i_req.mode == MODE_LOAD_L) || (i_req.mode == MODE_LOAD_R);
        w_rlim = (i_req.mode == MODE_LOAD_L) ? i_nr : i_nk;
        w_clim = (i_req.mode == MODE_LOAD_L) ? i_nk : i_nc;
        w_bad  = ({2'b0, i_req.row_index} >= w_rlim) || ({2'b0, i_req.col_index} >= w_clim);
        w_r    = IW'(i_req.row_index);
        w_c    = IW'(i_req.col_index);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_err_valid <= 1'b0;
            o_start     <= 1'b0;
            o_wr_l      <= 1'b0;
            o_wr_r      <= 1'b0;
        end else begin
            o_err_valid <= i_valid && w_load && w_bad;
            o_start     <= i_valid && (i_req.mode == MODE_START);
            o_wr_l      <= i_valid && (i_req.mode == MODE_LOAD_L) && !w_bad;
            o_wr_r      <= i_valid && (i_req.mode == MODE_LOAD_R) && !w_bad;
        end
        o_err     <= '{out_row: i_req.row_index, out_col: i_req.col_index,
                       prod_real: '0, prod_imag: '0, last_of_run: 1'b0, status: 1'b1};
        // row-major slot: row * MAX_DIM + col
        o_wr_addr <= AW'(w_r * MAX_DIM + w_c);
        o_wr_data <= {i_req.value_real, i_req.value_imag};
    end
endmodule

[hw/rtl/cmm_back.sv]
// Back end: stores and the multiply-accumulate sequencer.
`timescale 1ns / 1ps
module cmm_back import cmm_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [4:0] i_nr,
    input  logic [4:0] i_nk,
    input  logic [4:0] i_nc,
    input  logic       i_wr_l,
    input  logic       i_wr_r,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] i_wr_addr,
    input  logic [63:0] i_wr_data,
    output logic       o_busy,
    output logic       o_valid,
    output t_res       o_res
);
    localparam int AW = $clog2(MAX_DIM*MAX_DIM);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} t_state;

    logic [63:0] r_left [MAX_DIM*MAX_DIM];
    logic [63:0] r_right[MAX_DIM*MAX_DIM];
    logic [63:0] r_a, r_b;
    t_state      r_state;
    logic [4:0]  r_r, r_c, r_k;
    // pipeline tags: reads issued -> products -> accumulate
    logic        r_v1, r_first1, r_last1, r_v2, r_first2, r_last2, r_end2, r_end1;
    logic [2:0]  r_row1, r_col1, r_row2, r_col2;
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [ACC_W-1:0] r_acc_re, r_acc_im;
    logic        r_emit, r_emit_end;
    logic [2:0]  r_erow, r_ecol;
    logic        w_issue;
    logic        w_klast, w_rlast, w_clast;

    always_ff @(posedge i_clk) begin
        if (i_wr_l) r_left[i_wr_addr] <= i_wr_data;
        if (i_wr_r) r_right[i_wr_addr] <= i_wr_data;
        r_a <= r_left [AW'(r_r * MAX_DIM + r_k)];
        r_b <= r_right[AW'(r_k * MAX_DIM + r_c)];
    end

    assign w_klast = (r_k + 5'd1 == i_nk);
    assign w_rlast = (r_r + 5'd1 == i_nr);
    assign w_clast = (r_c + 5'd1 == i_nc);
    assign w_issue = (r_state == S_RUN);
    assign o_busy  = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_r <= '0; r_c <= '0; r_k <= '0;
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_emit <= 1'b0; o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_state <= S_RUN;
                    r_r <= '0; r_c <= '0; r_k <= '0;
                end
                S_RUN: begin
                    if (!w_klast) r_k <= r_k + 5'd1;
                    else begin
                        r_k <= '0;
                        if (!w_rlast) r_r <= r_r + 5'd1;
                        else begin
                            r_r <= '0;
                            if (!w_clast) r_c <= r_c + 5'd1;
                            else r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: if (o_valid && o_res.last_of_run) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_emit <= r_v2 && r_last2;
            o_valid <= r_emit;
        end
        r_first1 <= (r_k == 5'd0);
        r_last1  <= w_klast;
        r_end1   <= w_klast && w_rlast && w_clast;
        r_row1   <= r_r[2:0];
        r_col1   <= r_c[2:0];
        r_first2 <= r_first1; r_last2 <= r_last1; r_end2 <= r_end1;
        r_row2   <= r_row1;   r_col2  <= r_col1;
        r_p0 <= $signed(r_a[63:32]) * $signed(r_b[63:32]);
        r_p1 <= $signed(r_a[31:0])  * $signed(r_b[31:0]);
        r_p2 <= $signed(r_a[63:32]) * $signed(r_b[31:0]);
        r_p3 <= $signed(r_a[31:0])  * $signed(r_b[63:32]);
        if (r_v2) begin
            r_acc_re <= (r_first2 ? '0 : r_acc_re) + ACC_W'(r_p0) - ACC_W'(r_p1);
            r_acc_im <= (r_first2 ? '0 : r_acc_im) + ACC_W'(r_p2) + ACC_W'(r_p3);
        end
        r_emit_end <= r_end2;
        r_erow <= r_row2; r_ecol <= r_col2;
        o_res <= '{out_row: r_erow, out_col: r_ecol,
                   prod_real: acc_sat(r_acc_re), prod_imag: acc_sat(r_acc_im),
                   last_of_run: r_emit_end, status: 1'b0};
    end
endmodule

[sim/tb_complex_matrix_multiply_unit.sv]
// Self-checking testbench for the complex matrix multiplier: directed table plus random requests.
`timescale 1ns / 1ps
module tb_complex_matrix_multiply_unit;
    import cmm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         DIM         = 8;
    localparam logic signed [127:0] Q_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] Q_MIN = -Q_MAX - 128'sd1;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_req       i_req = '0;
    logic       o_strobe;
    t_res       o_res;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [3:0] i_cfg_data = '0;

    complex_matrix_multiply_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    // local copy of block state
    logic [31:0] lhs_re [DIM*DIM], lhs_im [DIM*DIM];
    logic [31:0] rhs_re [DIM*DIM], rhs_im [DIM*DIM];
    logic [3:0]  size_reg [3];
    t_res        expected_products [$];
    int          n_fail = 0;
    int          n_items = 0;
    bit          allow_idle = 1'b1;

    function automatic int eff_dim(logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > DIM) return DIM;
        return int'(v);
    endfunction

    function automatic logic [31:0] q824_sat(logic signed [127:0] acc);
        logic signed [127:0] s;
        s = acc >>> 24;
        if (s > Q_MAX) return 32'h7FFF_FFFF;
        if (s < Q_MIN) return 32'h8000_0000;
        return s[31:0];
    endfunction

    // updates stores and queues the product elements or error this request causes
    task automatic predict_matrix_item(t_req rq);
        int nr, nk, nc, rlim, clim;
        longint ar, ai, br, bi;
        logic signed [127:0] acc_re, acc_im;
        t_res e;
        nr = eff_dim(size_reg[CFG_ROWS]);
        nk = eff_dim(size_reg[CFG_INNER]);
        nc = eff_dim(size_reg[CFG_COLS]);
        if (rq.mode == MODE_LOAD_L || rq.mode == MODE_LOAD_R) begin
            rlim = (rq.mode == MODE_LOAD_L) ? nr : nk;
            clim = (rq.mode == MODE_LOAD_L) ? nk : nc;
            if (rq.row_index >= rlim || rq.col_index >= clim) begin
                e = '0;
                e.out_row = rq.row_index;
                e.out_col = rq.col_index;
                e.status = 1'b1;
                expected_products.push_back(e);
            end else if (rq.mode == MODE_LOAD_L) begin
                lhs_re[rq.row_index*DIM + rq.col_index] = rq.value_real;
                lhs_im[rq.row_index*DIM + rq.col_index] = rq.value_imag;
            end else begin
                rhs_re[rq.row_index*DIM + rq.col_index] = rq.value_real;
                rhs_im[rq.row_index*DIM + rq.col_index] = rq.value_imag;
            end
        end else if (rq.mode == MODE_START) begin
            for (int c = 0; c < nc; c++) begin
                for (int r = 0; r < nr; r++) begin
                    acc_re = '0;
                    acc_im = '0;
                    for (int k = 0; k < nk; k++) begin
                        ar = $signed(lhs_re[r*DIM + k]);
                        ai = $signed(lhs_im[r*DIM + k]);
                        br = $signed(rhs_re[k*DIM + c]);
                        bi = $signed(rhs_im[k*DIM + c]);
                        acc_re = acc_re + ar*br - ai*bi;
                        acc_im = acc_im + ar*bi + ai*br;
                    end
                    e.out_row = 3'(r);
                    e.out_col = 3'(c);
                    e.prod_real = q824_sat(acc_re);
                    e.prod_imag = q824_sat(acc_im);
                    e.last_of_run = (c == nc-1 && r == nr-1);
                    e.status = 1'b0;
                    expected_products.push_back(e);
                end
            end
        end
    endtask

    // drive one request and hold it until accepted; start is left high
    task automatic issue_request(t_req rq, bit typed = 1'b0, t_res typed_res = '0);
        int qlen;
        while (allow_idle && $urandom_range(0, 99) < 26) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_req = rq;
        do @(posedge i_clk); while (busy);
        qlen = expected_products.size();
        predict_matrix_item(rq);
        if (typed) begin
            while (expected_products.size() > qlen) void'(expected_products.pop_back());
            expected_products.push_back(typed_res);
        end
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (expected_products.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_size(logic [1:0] idx, logic [3:0] val);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx != CFG_UNUSED) size_reg[idx] = val;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            3: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
        endcase
    endfunction

    function automatic t_req load_req(logic [1:0] m, int r, int c);
        t_req rq;
        rq.mode = m;
        rq.row_index = 3'(r);
        rq.col_index = 3'(c);
        rq.value_real = pick_value();
        rq.value_imag = pick_value();
        return rq;
    endfunction

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_strobe) begin
            if (expected_products.size() == 0) begin
                $error("unexpected result row=%0d col=%0d", o_res.out_row, o_res.out_col);
                n_fail++;
            end else begin
                e = expected_products.pop_front();
                if (o_res.out_row !== e.out_row) begin
                    $error("out_row exp %0d got %0d", e.out_row, o_res.out_row); n_fail++;
                end
                if (o_res.out_col !== e.out_col) begin
                    $error("out_col exp %0d got %0d", e.out_col, o_res.out_col); n_fail++;
                end
                if (o_res.prod_real !== e.prod_real) begin
                    $error("prod_real exp %h got %h", e.prod_real, o_res.prod_real); n_fail++;
                end
                if (o_res.prod_imag !== e.prod_imag) begin
                    $error("prod_imag exp %h got %h", e.prod_imag, o_res.prod_imag); n_fail++;
                end
                if (o_res.last_of_run !== e.last_of_run) begin
                    $error("last_of_run exp %b got %b", e.last_of_run, o_res.last_of_run);
                    n_fail++;
                end
                if (o_res.status !== e.status) begin
                    $error("status exp %b got %b", e.status, o_res.status); n_fail++;
                end
            end
        end
    end

    typedef struct {
        bit         is_cfg;
        logic [1:0] cfg_idx;
        logic [3:0] cfg_val;
        t_req       rq;
        bit         typed;
        t_res       res;
    } t_row;

    function automatic t_row cfg_row(logic [1:0] idx, logic [3:0] v);
        t_row t = '{default: '0};
        t.is_cfg = 1'b1; t.cfg_idx = idx; t.cfg_val = v;
        return t;
    endfunction

    function automatic t_row req_row(logic [1:0] m, logic [2:0] r, logic [2:0] c,
                                     logic [31:0] vr, logic [31:0] vi, bit err = 1'b0);
        t_row t = '{default: '0};
        t.rq = '{m, r, c, vr, vi};
        t.typed = err;
        t.res = '{r, c, 32'h0, 32'h0, 1'b0, 1'b1};
        return t;
    endfunction

    initial begin
        t_row dir [$];
        t_req rq;
        int nr, nk, nc, pick;
        size_reg = '{4'd8, 4'd8, 4'd8};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill every entry once so no run ever reads an unwritten one
        for (int i = 0; i < DIM*DIM; i++) begin
            issue_request(load_req(MODE_LOAD_L, i / DIM, i % DIM));
            issue_request(load_req(MODE_LOAD_R, i / DIM, i % DIM));
        end
        issue_request(req_row(MODE_START, 0, 0, 0, 0).rq);

        dir.push_back(cfg_row(CFG_ROWS, 4'd3));
        dir.push_back(cfg_row(CFG_INNER, 4'd2));
        dir.push_back(cfg_row(CFG_COLS, 4'd4));
        dir.push_back(req_row(MODE_LOAD_L, 3, 0, 32'h1, 32'h2, 1'b1));
        dir.push_back(req_row(MODE_LOAD_L, 0, 2, 32'h1, 32'h2, 1'b1));
        dir.push_back(req_row(MODE_LOAD_R, 2, 0, 32'h1, 32'h2, 1'b1));
        dir.push_back(req_row(MODE_LOAD_R, 0, 4, 32'h1, 32'h2, 1'b1));
        dir.push_back(req_row(MODE_LOAD_L, 7, 7, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1));
        dir.push_back(req_row(MODE_UNUSED, 7, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        dir.push_back(cfg_row(CFG_UNUSED, 4'd0));
        dir.push_back(req_row(MODE_LOAD_L, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        dir.push_back(req_row(MODE_LOAD_R, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        dir.push_back(req_row(MODE_LOAD_L, 0, 1, 32'h8000_0000, 32'h8000_0000));
        dir.push_back(req_row(MODE_LOAD_R, 1, 0, 32'h8000_0000, 32'h8000_0000));
        dir.push_back(req_row(MODE_START, 0, 0, 0, 0));
        // zero acts as one, above eight clamps
        dir.push_back(cfg_row(CFG_ROWS, 4'd0));
        dir.push_back(cfg_row(CFG_INNER, 4'd15));
        dir.push_back(cfg_row(CFG_COLS, 4'd9));
        dir.push_back(req_row(MODE_START, 0, 0, 0, 0));
        dir.push_back(cfg_row(CFG_INNER, 4'd1));
        dir.push_back(cfg_row(CFG_COLS, 4'd1));
        dir.push_back(req_row(MODE_START, 0, 0, 0, 0));
        dir.push_back(cfg_row(CFG_ROWS, 4'd8));
        dir.push_back(cfg_row(CFG_INNER, 4'd8));
        dir.push_back(cfg_row(CFG_COLS, 4'd8));
        dir.push_back(req_row(MODE_START, 0, 0, 0, 0));
        foreach (dir[i]) begin
            if (dir[i].is_cfg) write_size(dir[i].cfg_idx, dir[i].cfg_val);
            else issue_request(dir[i].rq, dir[i].typed, dir[i].res);
        end

        while (n_items < 470) begin
            if (n_items % 40 < 1) begin
                for (int j = 0; j < 3; j++) begin
                    pick = $urandom_range(0, 9);
                    write_size(j[1:0], pick == 0 ? 4'd0 : pick == 1 ? 4'd15 :
                               pick < 4 ? 4'd1 : pick < 6 ? 4'd8 : 4'($urandom_range(1, 8)));
                end
                if ($urandom_range(0, 3) == 0) write_size(CFG_UNUSED, 4'($urandom()));
            end
            allow_idle = !(n_items >= 250 && n_items < 330);
            nr = eff_dim(size_reg[CFG_ROWS]);
            nk = eff_dim(size_reg[CFG_INNER]);
            nc = eff_dim(size_reg[CFG_COLS]);
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                if ($urandom_range(0, 1))
                    rq = load_req(MODE_LOAD_L, $urandom_range(0, nr-1), $urandom_range(0, nk-1));
                else
                    rq = load_req(MODE_LOAD_R, $urandom_range(0, nk-1), $urandom_range(0, nc-1));
            end else if (pick < 80) begin
                rq = load_req($urandom_range(0, 1) ? MODE_LOAD_L : MODE_LOAD_R,
                              $urandom_range(0, 7), $urandom_range(0, 7));
            end else if (pick < 95) begin
                rq = load_req(MODE_START, $urandom_range(0, 7), $urandom_range(0, 7));
            end else begin
                rq = load_req(MODE_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7));
            end
            issue_request(rq);
            // at item 400 the sender holds off until every expected result is back
            if (n_items == 400) wait_idle();
        end

        start = 1'b0;
        while (expected_products.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #8ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
